[rtl/anchor_box_landmark_decoder_top_defines.svh]
// ----------------------------------------------------------------------------
// Anchor box decoder assertion macros
// Concurrent assertion helpers clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ANCHOR_BOX_LANDMARK_DECODER_TOP_DEFINES_SVH
`define ANCHOR_BOX_LANDMARK_DECODER_TOP_DEFINES_SVH
`ifndef SYNTH
`define ABLD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ABLD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ABLD_ASSERT_IMP(lbl, ante, cons)
`define ABLD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/abld_pkg.sv]
// ----------------------------------------------------------------------------
// Anchor box decoder package
// Shared codes, register reset values, item types and exp tables.
// ----------------------------------------------------------------------------
package abld_pkg;

    localparam int MAX_GRID_DEF = 256;
    localparam int EDGE_W = 22;
    localparam int CALC_W = 44;

    localparam logic [1:0] ACT_CELL    = 2'd0;
    localparam logic [1:0] ACT_POINT   = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    localparam logic KIND_BOX   = 1'b0;
    localparam logic KIND_POINT = 1'b1;

    localparam logic [2:0] REG_THRESHOLD   = 3'd0;
    localparam logic [2:0] REG_STRIDE      = 3'd1;
    localparam logic [2:0] REG_GRID_W      = 3'd2;
    localparam logic [2:0] REG_ANCHOR_LEFT = 3'd3;
    localparam logic [2:0] REG_ANCHOR_TOP  = 3'd4;
    localparam logic [2:0] REG_ANCHOR_W    = 3'd5;
    localparam logic [2:0] REG_ANCHOR_H    = 3'd6;

    localparam logic [15:0] RST_THRESHOLD = 16'd45875;
    localparam logic [7:0]  RST_STRIDE    = 8'd32;
    localparam logic [8:0]  RST_GRID_W    = 9'd20;
    localparam logic [16:0] RST_ANCHOR_XY = 17'h1F080;
    localparam logic [15:0] RST_ANCHOR_WH = 16'd8192;

    typedef struct packed {
        logic [15:0] threshold;
        logic [7:0]  stride;
        logic [8:0]  grid_w;
        logic [16:0] anchor_left;
        logic [16:0] anchor_top;
        logic [15:0] anc_width;
        logic [15:0] anc_height;
    } cfg_t;

    typedef struct packed {
        logic                     kind;
        logic [15:0]              score;
        logic signed [15:0]       d_x;
        logic signed [15:0]       d_y;
        logic signed [15:0]       d_w;
        logic signed [15:0]       d_h;
        logic [2:0]               pidx;
        logic signed [EDGE_W-1:0] edge_x;
        logic signed [EDGE_W-1:0] edge_y;
        logic [7:0]               col;
        logic [7:0]               row;
    } q_entry_t;

    localparam logic [35:0] EXP_INT [16] = '{
        36'd5628, 36'd15299, 36'd41587, 36'd113044, 36'd307285, 36'd835288,
        36'd2270549, 36'd6171993, 36'd16777216, 36'd45605201, 36'd123967790,
        36'd336979392, 36'd916004956, 36'd2489959627, 36'd6768412009,
        36'd18398451372
    };
    localparam logic [17:0] EXP_FRAC [16] = '{
        18'd65536, 18'd69763, 18'd74262, 18'd79052, 18'd84150, 18'd89577,
        18'd95354, 18'd101504, 18'd108051, 18'd114619, 18'd122437, 18'd130334,
        18'd138740, 18'd147688, 18'd157213, 18'd167352
    };

    typedef logic [35:0] coarse_tab_t [256];
    typedef logic [16:0] poly_tab_t [256];

    function automatic coarse_tab_t build_coarse();
        coarse_tab_t t;
        logic [63:0] p;
        for (int i = 0; i < 256; i++)
        begin
            p = 64'(EXP_INT[i / 16]) * 64'(EXP_FRAC[i % 16]) + 64'd32768;
            t[i] = p[51:16];
        end
        return t;
    endfunction

    function automatic poly_tab_t build_poly();
        poly_tab_t t;
        logic [63:0] rq;
        logic [63:0] p;
        for (int i = 0; i < 256; i++)
        begin
            rq = 64'(i) * 64'd16;
            p = 64'd65536 + rq + ((rq * rq + 64'd65536) >> 17);
            t[i] = p[16:0];
        end
        return t;
    endfunction

    localparam coarse_tab_t EXP_COARSE = build_coarse();
    localparam poly_tab_t   EXP_POLY   = build_poly();

    function automatic logic signed [16:0] sat17(input logic signed [CALC_W-1:0] v);
        logic signed [16:0] r;
        if (v > 44'sd65535)
            r = 17'sd65535;
        else if (v < -44'sd65536)
            r = -17'sd65536;
        else
            r = v[16:0];
        return r;
    endfunction

endpackage

[rtl/abld_front.sv]
// ----------------------------------------------------------------------------
// Anchor box decoder front end
// Accepts items, tracks the grid position, applies the score threshold and
// queues the items that give a result.
// ----------------------------------------------------------------------------
module abld_front #(
    parameter int MAX_GRID = abld_pkg::MAX_GRID_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  abld_pkg::cfg_t     cfg,
    input  logic               s_tvalid,
    output logic               s_tready,
    // score, box_dx, box_dy, box_dw, box_dh, point_index, point_dx, point_dy
    input  logic [119:0]       s_tdata,
    // action
    input  logic [1:0]         s_tuser,
    output logic               q_push,
    output abld_pkg::q_entry_t q_data,
    input  logic               q_full
);

    localparam int CAP = (MAX_GRID < 256) ? MAX_GRID : 256;
    localparam logic [8:0] CAP_W = 9'(CAP);

    logic [7:0] col_reg;
    logic [7:0] row_reg;
    logic       passed_reg;

    logic        accept;
    logic        pass;
    logic [8:0]  eff_w;
    logic        wrap;
    logic [15:0] mx;
    logic [15:0] my;
    logic [7:0]  prev_col;
    logic [7:0]  prev_row;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign pass     = s_tdata[15:0] >= cfg.threshold;

    always_comb
    begin
        if (cfg.grid_w == 9'd0)
            eff_w = 9'd1;
        else if (cfg.grid_w > CAP_W)
            eff_w = CAP_W;
        else
            eff_w = cfg.grid_w;
    end

    assign wrap     = ({1'b0, col_reg} + 9'd1) >= eff_w;
    assign mx       = {8'd0, col_reg} * {8'd0, cfg.stride};
    assign my       = {8'd0, row_reg} * {8'd0, cfg.stride};
    assign prev_col = (col_reg == 8'd0) ? 8'(eff_w - 9'd1) : col_reg - 8'd1;
    assign prev_row = (col_reg == 8'd0) ? row_reg - 8'd1 : row_reg;

    always_comb
    begin
        q_data.kind   = (s_tuser == abld_pkg::ACT_POINT) ? abld_pkg::KIND_POINT
                                                         : abld_pkg::KIND_BOX;
        q_data.score  = s_tdata[15:0];
        q_data.d_x    = (s_tuser == abld_pkg::ACT_POINT) ? s_tdata[98:83] : s_tdata[31:16];
        q_data.d_y    = (s_tuser == abld_pkg::ACT_POINT) ? s_tdata[114:99] : s_tdata[47:32];
        q_data.d_w    = s_tdata[63:48];
        q_data.d_h    = s_tdata[79:64];
        q_data.pidx   = s_tdata[82:80];
        q_data.edge_x = abld_pkg::EDGE_W'(signed'(cfg.anchor_left))
                        + signed'({2'b00, mx, 4'b0000});
        q_data.edge_y = abld_pkg::EDGE_W'(signed'(cfg.anchor_top))
                        + signed'({2'b00, my, 4'b0000});
        q_data.col    = (s_tuser == abld_pkg::ACT_POINT) ? prev_col : col_reg;
        q_data.row    = (s_tuser == abld_pkg::ACT_POINT) ? prev_row : row_reg;
    end

    assign q_push = accept && (((s_tuser == abld_pkg::ACT_CELL) && pass)
                               || ((s_tuser == abld_pkg::ACT_POINT) && passed_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= 8'd0;
            row_reg    <= 8'd0;
            passed_reg <= 1'b0;
        end
        else if (accept)
        begin
            priority if (s_tuser == abld_pkg::ACT_RESTART)
            begin
                col_reg    <= 8'd0;
                row_reg    <= 8'd0;
                passed_reg <= 1'b0;
            end
            else if (s_tuser == abld_pkg::ACT_CELL)
            begin
                passed_reg <= pass;
                if (wrap)
                begin
                    col_reg <= 8'd0;
                    row_reg <= row_reg + 8'd1;
                end
                else
                begin
                    col_reg <= col_reg + 8'd1;
                end
            end
            else
            begin
                passed_reg <= passed_reg;
            end
        end
    end

endmodule

[rtl/abld_queue.sv]
// ----------------------------------------------------------------------------
// Anchor box decoder item queue
// Two-entry FIFO between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module abld_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  abld_pkg::q_entry_t push_data,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output abld_pkg::q_entry_t head
);

    abld_pkg::q_entry_t mem_reg [2];
    logic               wr_reg;
    logic               rd_reg;
    logic [1:0]         count_reg;

    assign full  = count_reg == 2'd2;
    assign valid = count_reg != 2'd0;
    assign head  = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= !wr_reg;
            if (pop)
                rd_reg <= !rd_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

[rtl/abld_back.sv]
// ----------------------------------------------------------------------------
// Anchor box decoder back end
// Decodes one queued item at a time on a shared 19x19 multiplier and holds
// the result in an output register.
// ----------------------------------------------------------------------------
`include "anchor_box_landmark_decoder_top_defines.svh"

module abld_back (
    input  logic               clk,
    input  logic               rst_n,
    input  abld_pkg::cfg_t     cfg,
    input  logic               q_valid,
    input  abld_pkg::q_entry_t q_data,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    // coord_x, coord_y, box_width, box_height, score_out, point_number,
    // cell_column, cell_row
    output logic [103:0]       m_tdata,
    // result_kind
    output logic               m_tuser
);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t                             state_reg;
    logic [3:0]                         step_reg;
    abld_pkg::q_entry_t                 ent_reg;
    logic [35:0]                        vx_reg, vy_reg;
    logic [16:0]                        polx_reg, poly_reg;
    logic signed [37:0]                 prod_reg;
    logic [34:0]                        lo_reg;
    logic [35:0]                        ex_reg, ey_reg;
    logic [39:0]                        sx_reg, sy_reg;
    logic signed [abld_pkg::CALC_W-1:0] px_reg, py_reg;
    logic signed [16:0]                 cx_reg, cy_reg;
    logic                               ov_reg;
    logic                               okind_reg;
    logic signed [16:0]                 ox_reg, oy_reg;
    logic [16:0]                        ow_reg, oh_reg;
    logic [15:0]                        oscore_reg;
    logic [2:0]                         onum_reg;
    logic [7:0]                         ocol_reg, orow_reg;

    logic                               finalize;
    logic                               out_free;
    logic [3:0]                         last_step;
    logic signed [18:0]                 mul_a, mul_b;
    logic signed [abld_pkg::CALC_W-1:0] c16x, c16y, prod_ext, pre_acc;
    logic [53:0]                        ex_sum;
    logic [52:0]                        s_sum;
    logic [15:0]                        ux, uy;
    logic signed [abld_pkg::CALC_W-1:0] ex0, ey0;
    logic [40:0]                        bw_sum, bh_sum;

    assign ux        = q_data.d_w ^ 16'h8000;
    assign uy        = q_data.d_h ^ 16'h8000;
    assign last_step = (ent_reg.kind == abld_pkg::KIND_POINT) ? 4'd3 : 4'd11;
    assign finalize  = (state_reg == ST_RUN) && (step_reg == last_step);
    assign out_free  = !ov_reg || m_tready;
    assign q_pop     = q_valid && (state_reg == ST_IDLE);

    assign c16x = (abld_pkg::CALC_W'(ent_reg.edge_x) <<< 12)
                  + signed'({16'd0, cfg.anc_width, 12'd0} >> 1);
    assign c16y = (abld_pkg::CALC_W'(ent_reg.edge_y) <<< 12)
                  + signed'({16'd0, cfg.anc_height, 12'd0} >> 1);
    assign prod_ext = abld_pkg::CALC_W'(prod_reg);
    assign ex_sum   = {prod_reg[35:0], 18'd0} + 54'(lo_reg) + 54'd32768;
    assign s_sum    = {prod_reg[34:0], 18'd0} + 53'(lo_reg) + 53'd2048;

    always_comb
    begin
        if (ent_reg.kind == abld_pkg::KIND_POINT)
        begin
            mul_a = (step_reg == 4'd0) ? signed'(19'(cfg.anc_width) + 19'd16)
                                       : signed'(19'(cfg.anc_height) + 19'd16);
            mul_b = (step_reg == 4'd0) ? 19'(ent_reg.d_x) : 19'(ent_reg.d_y);
        end
        else
        begin
            unique case (step_reg)
                4'd0:    begin mul_a = signed'({1'b0, vx_reg[17:0]});  mul_b = 19'(polx_reg); end
                4'd1:    begin mul_a = signed'({1'b0, vx_reg[35:18]}); mul_b = 19'(polx_reg); end
                4'd2:    begin mul_a = signed'({1'b0, vy_reg[17:0]});  mul_b = 19'(poly_reg); end
                4'd3:    begin mul_a = signed'({1'b0, vy_reg[35:18]}); mul_b = 19'(poly_reg); end
                4'd4:    begin mul_a = 19'(cfg.anc_width); mul_b = signed'({1'b0, ex_reg[17:0]}); end
                4'd5:    begin mul_a = 19'(cfg.anc_width); mul_b = signed'({1'b0, ex_reg[35:18]}); end
                4'd6:    begin mul_a = 19'(cfg.anc_height); mul_b = signed'({1'b0, ey_reg[17:0]}); end
                4'd7:    begin mul_a = 19'(cfg.anc_height); mul_b = signed'({1'b0, ey_reg[35:18]}); end
                4'd8:    begin mul_a = 19'(cfg.anc_width); mul_b = 19'(ent_reg.d_x); end
                4'd9:    begin mul_a = 19'(cfg.anc_height); mul_b = 19'(ent_reg.d_y); end
                default: begin mul_a = 19'sd0; mul_b = 19'sd0; end
            endcase
        end
    end

    always_comb
    begin
        if (ent_reg.kind == abld_pkg::KIND_POINT)
            pre_acc = (step_reg == 4'd1) ? (abld_pkg::CALC_W'(cx_reg) <<< 12)
                                         : (abld_pkg::CALC_W'(cy_reg) <<< 12);
        else
            pre_acc = (step_reg == 4'd9) ? c16x : c16y;
    end

    assign ex0    = (px_reg <<< 1) - signed'({4'd0, sx_reg});
    assign ey0    = (py_reg <<< 1) - signed'({4'd0, sy_reg});
    assign bw_sum = {1'b0, sx_reg} + 41'd67584;
    assign bh_sum = {1'b0, sy_reg} + 41'd67584;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 4'd0;
            ov_reg    <= 1'b0;
            cx_reg    <= 17'sd0;
            cy_reg    <= 17'sd0;
        end
        else
        begin
            if (ov_reg && m_tready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        ent_reg   <= q_data;
                        vx_reg    <= abld_pkg::EXP_COARSE[ux[15:8]];
                        vy_reg    <= abld_pkg::EXP_COARSE[uy[15:8]];
                        polx_reg  <= abld_pkg::EXP_POLY[ux[7:0]];
                        poly_reg  <= abld_pkg::EXP_POLY[uy[7:0]];
                        step_reg  <= 4'd0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (!finalize)
                    begin
                        prod_reg <= mul_a * mul_b;
                        step_reg <= step_reg + 4'd1;
                        if (ent_reg.kind == abld_pkg::KIND_POINT)
                        begin
                            if (step_reg == 4'd1)
                                px_reg <= pre_acc + prod_ext;
                            if (step_reg == 4'd2)
                                py_reg <= pre_acc + prod_ext;
                        end
                        else
                        begin
                            unique case (step_reg)
                                4'd1, 4'd3, 4'd5, 4'd7: lo_reg <= prod_reg[34:0];
                                4'd2:    ex_reg <= ex_sum[51:16];
                                4'd4:    ey_reg <= ex_sum[51:16];
                                4'd6:    sx_reg <= s_sum[51:12];
                                4'd8:    sy_reg <= s_sum[51:12];
                                4'd9:    px_reg <= pre_acc + prod_ext;
                                4'd10:   py_reg <= pre_acc + prod_ext;
                                default: lo_reg <= lo_reg;
                            endcase
                        end
                    end
                    else if (out_free)
                    begin
                        ov_reg     <= 1'b1;
                        okind_reg  <= ent_reg.kind;
                        ocol_reg   <= ent_reg.col;
                        orow_reg   <= ent_reg.row;
                        state_reg  <= ST_IDLE;
                        step_reg   <= 4'd0;
                        if (ent_reg.kind == abld_pkg::KIND_POINT)
                        begin
                            ox_reg     <= abld_pkg::sat17((px_reg + 44'sd2048) >>> 12);
                            oy_reg     <= abld_pkg::sat17((py_reg + 44'sd2048) >>> 12);
                            ow_reg     <= 17'd0;
                            oh_reg     <= 17'd0;
                            oscore_reg <= 16'd0;
                            onum_reg   <= ent_reg.pidx;
                        end
                        else
                        begin
                            ox_reg     <= abld_pkg::sat17((ex0 + 44'sd4096) >>> 13);
                            oy_reg     <= abld_pkg::sat17((ey0 + 44'sd4096) >>> 13);
                            ow_reg     <= (bw_sum[40:12] > 29'd131071) ? 17'h1FFFF
                                                                       : bw_sum[28:12];
                            oh_reg     <= (bh_sum[40:12] > 29'd131071) ? 17'h1FFFF
                                                                       : bh_sum[28:12];
                            oscore_reg <= ent_reg.score;
                            onum_reg   <= 3'd0;
                            cx_reg     <= abld_pkg::sat17((c16x + 44'sd2048) >>> 12);
                            cy_reg     <= abld_pkg::sat17((c16y + 44'sd2048) >>> 12);
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = okind_reg;
    assign m_tdata  = {1'b0, orow_reg, ocol_reg, onum_reg, oscore_reg, oh_reg, ow_reg,
                       oy_reg, ox_reg};

    `ABLD_ASSERT_NEXT(a_hold_final, finalize && !out_free, (state_reg == ST_RUN) && $stable(step_reg))
    `ABLD_ASSERT_IMP(a_idle_step, state_reg == ST_IDLE, step_reg == 4'd0)
    `ABLD_ASSERT_IMP(a_box_num, ov_reg && (okind_reg == abld_pkg::KIND_BOX), onum_reg == 3'd0)
    `ABLD_ASSERT_IMP(a_point_zero, ov_reg && (okind_reg == abld_pkg::KIND_POINT), (ow_reg == 17'd0) && (oscore_reg == 16'd0))

endmodule

[rtl/anchor_box_landmark_decoder_top.sv]
// ----------------------------------------------------------------------------
// Anchor box and keypoint decoder, top level
// Front end, item queue, multiplier back end and APB register file.
// ----------------------------------------------------------------------------
// Items that give no result (failing cells, keypoints after a failing cell,
// restarts) never enter the queue. Passing cells and keypoints are decoded in
// the back end one at a time on the single shared 19x19 multiplier, which walks
// the exp and scale products in turn; a two-entry queue lets the front end keep
// accepting and counting cells meanwhile. Registers are written over APB at
// byte address 4*index and must only change while the block is idle.
module anchor_box_landmark_decoder_top #(
    parameter int MAX_GRID = abld_pkg::MAX_GRID_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // score, box_dx, box_dy, box_dw, box_dh, point_index, point_dx, point_dy
    input  logic [119:0] s_tdata,
    // action
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // coord_x, coord_y, box_width, box_height, score_out, point_number,
    // cell_column, cell_row
    output logic [103:0] m_tdata,
    // result_kind
    output logic         m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    abld_pkg::cfg_t     cfg_reg;
    logic               q_push, q_full, q_pop, q_valid;
    abld_pkg::q_entry_t q_in, q_head;
    logic [2:0]         reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold   <= abld_pkg::RST_THRESHOLD;
            cfg_reg.stride      <= abld_pkg::RST_STRIDE;
            cfg_reg.grid_w      <= abld_pkg::RST_GRID_W;
            cfg_reg.anchor_left <= abld_pkg::RST_ANCHOR_XY;
            cfg_reg.anchor_top  <= abld_pkg::RST_ANCHOR_XY;
            cfg_reg.anc_width   <= abld_pkg::RST_ANCHOR_WH;
            cfg_reg.anc_height  <= abld_pkg::RST_ANCHOR_WH;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_idx)
                abld_pkg::REG_THRESHOLD:   cfg_reg.threshold   <= pwdata[15:0];
                abld_pkg::REG_STRIDE:      cfg_reg.stride      <= pwdata[7:0];
                abld_pkg::REG_GRID_W:      cfg_reg.grid_w      <= pwdata[8:0];
                abld_pkg::REG_ANCHOR_LEFT: cfg_reg.anchor_left <= pwdata[16:0];
                abld_pkg::REG_ANCHOR_TOP:  cfg_reg.anchor_top  <= pwdata[16:0];
                abld_pkg::REG_ANCHOR_W:    cfg_reg.anc_width   <= pwdata[15:0];
                abld_pkg::REG_ANCHOR_H:    cfg_reg.anc_height  <= pwdata[15:0];
                default:                   cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            abld_pkg::REG_THRESHOLD:   prdata = 32'(cfg_reg.threshold);
            abld_pkg::REG_STRIDE:      prdata = 32'(cfg_reg.stride);
            abld_pkg::REG_GRID_W:      prdata = 32'(cfg_reg.grid_w);
            abld_pkg::REG_ANCHOR_LEFT: prdata = 32'(cfg_reg.anchor_left);
            abld_pkg::REG_ANCHOR_TOP:  prdata = 32'(cfg_reg.anchor_top);
            abld_pkg::REG_ANCHOR_W:    prdata = 32'(cfg_reg.anc_width);
            abld_pkg::REG_ANCHOR_H:    prdata = 32'(cfg_reg.anc_height);
            default:                   prdata = 32'd0;
        endcase
    end

    abld_front #(
        .MAX_GRID (MAX_GRID)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_push   (q_push),
        .q_data   (q_in),
        .q_full   (q_full)
    );

    abld_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    abld_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_data   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// Anchor box decoder testbench
// Streams cell, keypoint and restart items through the decoder under several
// register settings. The sender works in bursts and the receiver stalls.
// A scoreboard predicts every box and keypoint and checks each result in
// order.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic               kind;
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic [16:0]        w;
        logic [16:0]        h;
        logic [15:0]        score;
        logic [2:0]         pnum;
        logic [7:0]         col;
        logic [7:0]         row;
    } decoded_t;

    typedef struct {
        logic [1:0]  action;
        logic [15:0] score;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] dw;
        logic [15:0] dh;
        logic [2:0]  pidx;
        logic [15:0] pdx;
        logic [15:0] pdy;
    } item_t;

    class anchor_decode_board;
        decoded_t    expected_results[$];
        logic [15:0] threshold;
        logic [7:0]  stride;
        logic [8:0]  grid_w;
        logic [16:0] anchor_left;
        logic [16:0] anchor_top;
        logic [15:0] anc_width;
        logic [15:0] anc_height;
        int          column_count;
        int          row_count;
        bit          cell_passed;
        longint      center_x;
        longint      center_y;

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                abld_pkg::REG_THRESHOLD:   threshold = v[15:0];
                abld_pkg::REG_STRIDE:      stride = v[7:0];
                abld_pkg::REG_GRID_W:      grid_w = v[8:0];
                abld_pkg::REG_ANCHOR_LEFT: anchor_left = v[16:0];
                abld_pkg::REG_ANCHOR_TOP:  anchor_top = v[16:0];
                abld_pkg::REG_ANCHOR_W:    anc_width = v[15:0];
                abld_pkg::REG_ANCHOR_H:    anc_height = v[15:0];
                default: ;
            endcase
        endfunction

        function void clear();
            threshold = abld_pkg::RST_THRESHOLD;
            stride = abld_pkg::RST_STRIDE;
            grid_w = abld_pkg::RST_GRID_W;
            anchor_left = abld_pkg::RST_ANCHOR_XY;
            anchor_top = abld_pkg::RST_ANCHOR_XY;
            anc_width = abld_pkg::RST_ANCHOR_WH;
            anc_height = abld_pkg::RST_ANCHOR_WH;
            column_count = 0;
            row_count = 0;
            cell_passed = 0;
            center_x = 0;
            center_y = 0;
            expected_results.delete();
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function longint round_shift(longint v, int n);
            return (v + (64'sd1 <<< (n - 1))) >>> n;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function int grid_span();
            if (grid_w == 0)
                return 1;
            if (grid_w > 256)
                return 256;
            return grid_w;
        endfunction

        function longint unsigned exp_of(longint d);
            longint unsigned u;
            longint unsigned v;
            longint unsigned rq;
            longint unsigned poly;
            u = longint'(d + 32768);
            v = (64'(abld_pkg::EXP_INT[(u >> 12) & 15])
                 * 64'(abld_pkg::EXP_FRAC[(u >> 8) & 15]) + 32768) >> 16;
            rq = (u & 255) << 4;
            poly = 65536 + rq + ((rq * rq + 65536) >> 17);
            return (v * poly + 32768) >> 16;
        endfunction

        function longint edge_of(longint edge0, longint size, longint d, longint dl,
                                 output longint center, output longint size_out);
            longint c16;
            longint p16;
            longint s16;
            c16 = edge0 * 4096 + size * 2048;
            p16 = c16 + size * d;
            s16 = longint'((64'(size) * exp_of(dl) + 2048) >> 12);
            center = clip(round_shift(c16, 12), -65536, 65535);
            size_out = clip(round_shift(s16 + 65536, 12), 0, 131071);
            return clip(round_shift(2 * p16 - s16, 13), -65536, 65535);
        endfunction

        function void note_item(item_t it);
            decoded_t r;
            longint bw;
            longint bh;
            longint px;
            longint py;
            int col;
            int row;
            col = column_count;
            row = row_count;
            if (it.action == abld_pkg::ACT_RESTART)
            begin
                column_count = 0;
                row_count = 0;
                cell_passed = 0;
            end
            else if (it.action == abld_pkg::ACT_CELL)
            begin
                cell_passed = it.score >= threshold;
                if (cell_passed)
                begin
                    r.kind = abld_pkg::KIND_BOX;
                    r.x = 17'(edge_of(longint'($signed(anchor_left)) + col * stride * 16,
                                      anc_width, longint'($signed(it.dx)),
                                      longint'($signed(it.dw)), center_x, bw));
                    r.y = 17'(edge_of(longint'($signed(anchor_top)) + row * stride * 16,
                                      anc_height, longint'($signed(it.dy)),
                                      longint'($signed(it.dh)), center_y, bh));
                    r.w = 17'(bw);
                    r.h = 17'(bh);
                    r.score = it.score;
                    r.pnum = 3'd0;
                    r.col = 8'(col);
                    r.row = 8'(row);
                    expected_results = {expected_results, r};
                end
                col++;
                if (col >= grid_span())
                begin
                    col = 0;
                    row = (row + 1) & 255;
                end
                column_count = col & 255;
                row_count = row;
            end
            else if (it.action == abld_pkg::ACT_POINT && cell_passed)
            begin
                px = center_x * 4096 + (longint'(anc_width) + 16) * longint'($signed(it.pdx));
                py = center_y * 4096 + (longint'(anc_height) + 16) * longint'($signed(it.pdy));
                if (col == 0)
                begin
                    col = grid_span() - 1;
                    row = (row + 255) & 255;
                end
                else
                    col--;
                r.kind = abld_pkg::KIND_POINT;
                r.x = 17'(clip(round_shift(px, 12), -65536, 65535));
                r.y = 17'(clip(round_shift(py, 12), -65536, 65535));
                r.w = 17'd0;
                r.h = 17'd0;
                r.score = 16'd0;
                r.pnum = it.pidx;
                r.col = 8'(col);
                r.row = 8'(row);
                expected_results = {expected_results, r};
            end
        endfunction

        function string check_result(decoded_t got);
            decoded_t e;
            string s;
            if (expected_results.size() == 0)
                return "result with nothing expected";
            e = expected_results.pop_front();
            s = "";
            if (got.kind !== e.kind)
                s = {s, $sformatf(" kind %0d/%0d", got.kind, e.kind)};
            if (got.x !== e.x)
                s = {s, $sformatf(" x %0d/%0d", got.x, e.x)};
            if (got.y !== e.y)
                s = {s, $sformatf(" y %0d/%0d", got.y, e.y)};
            if (got.w !== e.w)
                s = {s, $sformatf(" w %0d/%0d", got.w, e.w)};
            if (got.h !== e.h)
                s = {s, $sformatf(" h %0d/%0d", got.h, e.h)};
            if (got.score !== e.score)
                s = {s, $sformatf(" score %0d/%0d", got.score, e.score)};
            if (got.pnum !== e.pnum)
                s = {s, $sformatf(" point %0d/%0d", got.pnum, e.pnum)};
            if (got.col !== e.col)
                s = {s, $sformatf(" col %0d/%0d", got.col, e.col)};
            if (got.row !== e.row)
                s = {s, $sformatf(" row %0d/%0d", got.row, e.row)};
            return s;
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // score, box_dx, box_dy, box_dw, box_dh, point_index, point_dx, point_dy
    logic [119:0] s_tdata;
    // action
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // coord_x, coord_y, box_width, box_height, score_out, point_number,
    // cell_column, cell_row
    logic [103:0] m_tdata;
    // result_kind
    logic         m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    anchor_decode_board board;
    int  errors;
    int  cycles;
    int  burst_left;
    int  item_count;
    int  stall_mode;
    bit  hold_req;

    anchor_box_landmark_decoder_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    task automatic report(string msg);
        $display("mismatch at cycle %0d:%s", cycles, msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 500000)
        begin
            $display("timeout");
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        decoded_t got;
        string    msg;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind = m_tuser;
            got.x = m_tdata[16:0];
            got.y = m_tdata[33:17];
            got.w = m_tdata[50:34];
            got.h = m_tdata[67:51];
            got.score = m_tdata[83:68];
            got.pnum = m_tdata[86:84];
            got.col = m_tdata[94:87];
            got.row = m_tdata[102:95];
            msg = board.check_result(got);
            if (msg != "")
                report(msg);
        end
    end

    // receiver: switches between random stall patterns and holds ready low on a hold request
    initial
    begin
        int left;
        int held;
        left = 0;
        m_tready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 0;
                for (held = 0; held < 300; held++)
                    @(negedge clk);
                hold_req = 0;
            end
            if (left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                left = $urandom_range(10, 60);
            end
            left--;
            case (stall_mode)
                0: m_tready = 1;
                1: m_tready = $urandom_range(0, 1);
                2: m_tready = ($urandom_range(0, 7) == 0);
                default: m_tready = ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic send(item_t it);
        int gap;
        if (burst_left == 0)
        begin
            s_tvalid = 0;
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_tuser = it.action;
        s_tdata = {5'd0, it.pdy, it.pdx, it.pidx, it.dh, it.dw, it.dy, it.dx, it.score};
        s_tvalid = 1;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_item(it);
        if (it.action != ACT_UNUSED)
            item_count++;
        @(negedge clk);
    endtask

    task automatic apb_write(logic [2:0] idx, logic [31:0] v);
        psel = 1;
        pwrite = 1;
        penable = 0;
        paddr = {idx, 2'b00};
        pwdata = v;
        @(negedge clk);
        penable = 1;
        do
            @(posedge clk);
        while (!pready);
        board.set_reg(idx, v);
        @(negedge clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
    endtask

    task automatic drain();
        s_tvalid = 0;
        burst_left = 0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    function automatic logic [15:0] rand_delta();
        int v;
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom());
        v = $urandom_range(0, 8192);
        return 16'(v - 4096);
    endfunction

    function automatic item_t make_item(logic [1:0] act, logic [15:0] thr);
        item_t it;
        it.action = act;
        it.score = $urandom_range(0, 1) ? 16'($urandom_range(thr, 65535)) : 16'($urandom());
        it.dx = rand_delta();
        it.dy = rand_delta();
        it.dw = rand_delta();
        it.dh = rand_delta();
        it.pidx = 3'($urandom());
        it.pdx = rand_delta();
        it.pdy = rand_delta();
        return it;
    endfunction

    task automatic send_point(logic [2:0] idx, logic [15:0] pdx, logic [15:0] pdy);
        item_t it;
        it = make_item(abld_pkg::ACT_POINT, 0);
        it.pidx = idx;
        it.pdx = pdx;
        it.pdy = pdy;
        send(it);
    endtask

    task automatic send_cell(logic [15:0] sc, logic [15:0] d);
        item_t it;
        it = make_item(abld_pkg::ACT_CELL, 0);
        it.score = sc;
        it.dx = d;
        it.dy = d;
        it.dw = d;
        it.dh = d;
        send(it);
    endtask

    task automatic random_items(int count);
        item_t it;
        int    r;
        int    k;
        int    target;
        target = item_count + count;
        while (item_count < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                it = make_item(abld_pkg::ACT_CELL, board.threshold);
                send(it);
                for (k = 0; k < 5; k++)
                begin
                    it = make_item(abld_pkg::ACT_POINT, 0);
                    it.pidx = 3'(k);
                    send(it);
                end
            end
            else if (r < 80)
                send(make_item(abld_pkg::ACT_CELL, board.threshold));
            else if (r < 90)
                send(make_item(abld_pkg::ACT_POINT, 0));
            else if (r < 95)
                send(make_item(abld_pkg::ACT_RESTART, 0));
            else
                send(make_item(ACT_UNUSED, 0));
        end
    endtask

    task automatic write_all(logic [31:0] thr, logic [31:0] str, logic [31:0] gw,
                             logic [31:0] al, logic [31:0] at, logic [31:0] aw,
                             logic [31:0] ah);
        apb_write(abld_pkg::REG_THRESHOLD, thr);
        apb_write(abld_pkg::REG_STRIDE, str);
        apb_write(abld_pkg::REG_GRID_W, gw);
        apb_write(abld_pkg::REG_ANCHOR_LEFT, al);
        apb_write(abld_pkg::REG_ANCHOR_TOP, at);
        apb_write(abld_pkg::REG_ANCHOR_W, aw);
        apb_write(abld_pkg::REG_ANCHOR_H, ah);
    endtask

    initial
    begin
        int ph;
        board = new();
        board.clear();
        errors = 0;
        cycles = 0;
        burst_left = 0;
        item_count = 0;
        hold_req = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = abld_pkg::ACT_CELL;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        repeat (8) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: extremes, every action, and the corner cases
        send_point(0, 16'h7FFF, 16'h8000);
        send_cell(16'hFFFF, 16'h7FFF);
        send_point(0, 16'h7FFF, 16'h7FFF);
        send_point(1, 16'h8000, 16'h8000);
        send_point(2, 16'h0000, 16'hFFFF);
        send_point(3, 16'h1000, 16'hF000);
        send_point(4, 16'h8000, 16'h7FFF);
        send_point(4, 16'h0001, 16'h0001);
        send_point(7, 16'h0800, 16'h0800);
        send_point(5, 16'hFFFF, 16'h0000);
        send_cell(16'hFFFF, 16'h8000);
        send_point(0, 16'h0000, 16'h0000);
        send_cell(abld_pkg::RST_THRESHOLD, 16'h0000);
        send_cell(abld_pkg::RST_THRESHOLD - 16'd1, 16'h0000);
        send_point(1, 16'h0100, 16'h0100);
        send(make_item(ACT_UNUSED, 0));
        send_cell(16'hFFFF, 16'h0FFF);
        send(make_item(abld_pkg::ACT_RESTART, 0));
        send_point(2, 16'h0100, 16'h0100);
        send_cell(16'h0000, 16'h7FFF);
        random_items(200);
        drain();

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_all(0, 0, 0, 32'h10000, 32'h10000, 0, 65535);
                1: write_all(65535, 255, 511, 65535, 32'h10000, 65535, 0);
                2: write_all(0, 1, 1, 0, 65535, 16, 65535);
                default: write_all($urandom_range(0, 60000), $urandom_range(1, 128),
                                   $urandom_range(1, 256), $urandom_range(0, 131071),
                                   $urandom_range(0, 131071), $urandom_range(0, 65535),
                                   $urandom_range(0, 65535));
            endcase
            if (ph == 3)
                hold_req = 1;
            random_items(240);
            drain();
        end

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl
rtl/abld_pkg.sv
rtl/abld_front.sv
rtl/abld_queue.sv
rtl/abld_back.sv
rtl/anchor_box_landmark_decoder_top.sv
test/tb.sv
